FILE: src/udcc_pkg.sv
// Types and constants shared by the up/down calendar clock.
// Holds the command and result word layouts, step codes and the month table.
// No dependencies.
package udcc_pkg;

  typedef enum logic [3:0] {
    KIND_SEC_UP   = 4'd0,
    KIND_SEC_DN   = 4'd1,
    KIND_MIN_UP   = 4'd2,
    KIND_MIN_DN   = 4'd3,
    KIND_HOUR_UP  = 4'd4,
    KIND_HOUR_DN  = 4'd5,
    KIND_DAY_UP   = 4'd6,
    KIND_DAY_DN   = 4'd7,
    KIND_LOAD     = 4'd8
  } kind_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [15:0] load_year;
  } cmd_t;

  // Result word; also serves as the clock state.
  typedef struct packed {
    logic [5:0]  out_second;
    logic [5:0]  out_minute;
    logic [4:0]  out_hour;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [15:0] out_year;
  } res_t;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [4:0]  DAY_FIRST  = 5'd1;
  localparam logic [15:0] YEAR_RESET = 16'd2000;

  // Fixed month lengths, February always 29; invalid months have length 0.
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
      4'd2:                                        d = 5'd29;
      default:                                     d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: src/udcc_step.sv
// Next-state logic of the calendar clock: one step or load applied to the state.
// Carries and borrows ripple second -> minute -> hour -> day -> month -> year.
// Depends on udcc_pkg.
module udcc_step (
  input  udcc_pkg::res_t cur,
  input  udcc_pkg::cmd_t cmd,
  output udcc_pkg::res_t nxt
);
  import udcc_pkg::*;

  logic       min_up, min_dn, hour_up, hour_dn, day_up, day_dn;
  logic [3:0] month_new;

  always_comb begin
    nxt       = cur;
    min_up    = 1'b0;
    min_dn    = 1'b0;
    hour_up   = 1'b0;
    hour_dn   = 1'b0;
    day_up    = 1'b0;
    day_dn    = 1'b0;
    month_new = cur.out_month;

    case (cmd.kind)
      KIND_SEC_UP: begin
        if (cur.out_second >= SEC_LAST) begin
          nxt.out_second = '0;
          min_up = 1'b1;
        end else begin
          nxt.out_second = cur.out_second + 6'd1;
        end
      end
      KIND_SEC_DN: begin
        if (cur.out_second == '0) begin
          nxt.out_second = SEC_LAST;
          min_dn = 1'b1;
        end else begin
          nxt.out_second = cur.out_second - 6'd1;
        end
      end
      KIND_MIN_UP:  min_up  = 1'b1;
      KIND_MIN_DN:  min_dn  = 1'b1;
      KIND_HOUR_UP: hour_up = 1'b1;
      KIND_HOUR_DN: hour_dn = 1'b1;
      KIND_DAY_UP:  day_up  = 1'b1;
      KIND_DAY_DN:  day_dn  = 1'b1;
      KIND_LOAD: begin
        nxt.out_second = cmd.load_second;
        nxt.out_minute = cmd.load_minute;
        nxt.out_hour   = cmd.load_hour;
        nxt.out_day    = cmd.load_day;
        nxt.out_month  = cmd.load_month;
        nxt.out_year   = cmd.load_year;
      end
      default: ;
    endcase

    if (min_up) begin
      if (cur.out_minute >= MIN_LAST) begin
        nxt.out_minute = '0;
        hour_up = 1'b1;
      end else begin
        nxt.out_minute = cur.out_minute + 6'd1;
      end
    end
    if (min_dn) begin
      if (cur.out_minute == '0) begin
        nxt.out_minute = MIN_LAST;
        hour_dn = 1'b1;
      end else begin
        nxt.out_minute = cur.out_minute - 6'd1;
      end
    end

    if (hour_up) begin
      if (cur.out_hour >= HOUR_LAST) begin
        nxt.out_hour = '0;
        day_up = 1'b1;
      end else begin
        nxt.out_hour = cur.out_hour + 5'd1;
      end
    end
    if (hour_dn) begin
      if (cur.out_hour == '0) begin
        nxt.out_hour = HOUR_LAST;
        day_dn = 1'b1;
      end else begin
        nxt.out_hour = cur.out_hour - 5'd1;
      end
    end

    if (day_up) begin
      // invalid month has length 0, so the day always carries
      if (cur.out_day >= month_days(cur.out_month)) begin
        nxt.out_day = DAY_FIRST;
        if (cur.out_month >= MONTH_LAST) begin
          nxt.out_month = MONTH_FIRST;
          nxt.out_year  = cur.out_year + 16'd1;
        end else begin
          nxt.out_month = cur.out_month + 4'd1;
        end
      end else begin
        nxt.out_day = cur.out_day + 5'd1;
      end
    end
    if (day_dn) begin
      if (cur.out_day <= DAY_FIRST) begin
        if (cur.out_month <= MONTH_FIRST) begin
          month_new    = MONTH_LAST;
          nxt.out_year = cur.out_year - 16'd1;
        end else if (cur.out_month > MONTH_LAST) begin
          month_new = MONTH_LAST;
        end else begin
          month_new = cur.out_month - 4'd1;
        end
        nxt.out_month = month_new;
        nxt.out_day   = month_days(month_new);
      end else begin
        nxt.out_day = cur.out_day - 5'd1;
      end
    end
  end

endmodule

FILE: src/up_down_calendar_clock.sv
// Up/down calendar clock, top level.
// Holds the clock state and the result register; depends on udcc_pkg, udcc_step.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd): one word per step. kind selects
//   second, minute, hour or day up/down, or a load of all six fields.
//   Unused kinds leave the clock as it is and still return a result.
//   res channel (res_valid/res_ready/res): one word per command, the date
//   and time after that step.
// Latency: the result is valid in the cycle after the command is accepted.
// Throughput: one command per cycle while the result side keeps up; the whole
//   carry/borrow chain and month table lookup feed the registers combinationally.
// Stall: cmd_ready is high while the result register is empty or being
//   drained this cycle; a held result blocks new commands until taken.
// Reset: rst (synchronous) sets 00:00:00, day 1, month 1, year 2000 and
//   empties the result register.
module up_down_calendar_clock (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  udcc_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output udcc_pkg::res_t res
);
  import udcc_pkg::*;

  res_t cal;
  res_t cal_next;
  logic cmd_fire;

  udcc_step u_step (
    .cur (cal),
    .cmd (cmd),
    .nxt (cal_next)
  );

  assign cmd_ready = !res_valid || res_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal.out_second <= '0;
      cal.out_minute <= '0;
      cal.out_hour   <= '0;
      cal.out_day    <= DAY_FIRST;
      cal.out_month  <= MONTH_FIRST;
      cal.out_year   <= YEAR_RESET;
      res_valid      <= 1'b0;
    end else if (cmd_fire) begin
      cal       <= cal_next;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res <= cal_next;
    end
  end

endmodule

FILE: sim/up_down_calendar_clock_test.sv
// Self-checking testbench for the up/down calendar clock.
// Drives command words with random gaps and result stalls; a scoreboard
// class predicts every result word. Depends on udcc_pkg and up_down_calendar_clock.
module up_down_calendar_clock_test;
  import udcc_pkg::*;

  localparam int          RANDOM_ITEMS  = 700;
  localparam int          MAX_GAP       = 13;
  localparam int          HOLD_AT       = 120;   // result count that starts the long hold-off
  localparam int          HOLD_CYCLES   = 300;
  localparam int          STALL_LIMIT   = 3000;  // cycles with no word moving on either side
  localparam logic [3:0]  KIND_SPARE_LO = KIND_LOAD + 4'd1;
  localparam logic [3:0]  KIND_SPARE_HI = 4'hF;

  class clock_tracker;
    localparam logic [5:0] TOP_SEC   = 6'd59;
    localparam logic [5:0] TOP_MIN   = 6'd59;
    localparam logic [4:0] TOP_HOUR  = 5'd23;
    localparam logic [3:0] TOP_MONTH = 4'd12;

    res_t       now_state;
    res_t       expected_times[$];
    logic [4:0] days_tab[16];
    int         errors;

    function new();
      now_state.out_second = 6'd0;
      now_state.out_minute = 6'd0;
      now_state.out_hour   = 5'd0;
      now_state.out_day    = 5'd1;
      now_state.out_month  = 4'd1;
      now_state.out_year   = 16'd2000;
      // February always 29 days; invalid months count as zero days
      days_tab = '{5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
                   5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0};
      errors = 0;
    endfunction

    // One step of the clock; carries and borrows ripple upward through flags.
    function res_t step_clock(res_t s, cmd_t c);
      res_t n;
      logic carry_m, carry_h, carry_d, borrow_m, borrow_h, borrow_d;
      n        = s;
      carry_m  = (c.kind == KIND_MIN_UP);
      carry_h  = (c.kind == KIND_HOUR_UP);
      carry_d  = (c.kind == KIND_DAY_UP);
      borrow_m = (c.kind == KIND_MIN_DN);
      borrow_h = (c.kind == KIND_HOUR_DN);
      borrow_d = (c.kind == KIND_DAY_DN);
      if (c.kind == KIND_LOAD) begin
        n.out_second = c.load_second;
        n.out_minute = c.load_minute;
        n.out_hour   = c.load_hour;
        n.out_day    = c.load_day;
        n.out_month  = c.load_month;
        n.out_year   = c.load_year;
      end
      if (c.kind == KIND_SEC_UP) begin
        if (n.out_second >= TOP_SEC) begin
          n.out_second = 6'd0;
          carry_m = 1'b1;
        end else n.out_second = n.out_second + 6'd1;
      end
      if (c.kind == KIND_SEC_DN) begin
        if (n.out_second == 6'd0) begin
          n.out_second = TOP_SEC;
          borrow_m = 1'b1;
        end else n.out_second = n.out_second - 6'd1;
      end
      if (carry_m) begin
        if (n.out_minute >= TOP_MIN) begin
          n.out_minute = 6'd0;
          carry_h = 1'b1;
        end else n.out_minute = n.out_minute + 6'd1;
      end
      if (borrow_m) begin
        if (n.out_minute == 6'd0) begin
          n.out_minute = TOP_MIN;
          borrow_h = 1'b1;
        end else n.out_minute = n.out_minute - 6'd1;
      end
      if (carry_h) begin
        if (n.out_hour >= TOP_HOUR) begin
          n.out_hour = 5'd0;
          carry_d = 1'b1;
        end else n.out_hour = n.out_hour + 5'd1;
      end
      if (borrow_h) begin
        if (n.out_hour == 5'd0) begin
          n.out_hour = TOP_HOUR;
          borrow_d = 1'b1;
        end else n.out_hour = n.out_hour - 5'd1;
      end
      if (carry_d) begin
        if (n.out_day >= days_tab[n.out_month]) begin
          n.out_day = 5'd1;
          if (n.out_month >= TOP_MONTH) begin
            n.out_month = 4'd1;
            n.out_year  = n.out_year + 16'd1;
          end else n.out_month = n.out_month + 4'd1;
        end else n.out_day = n.out_day + 5'd1;
      end
      if (borrow_d) begin
        if (n.out_day <= 5'd1) begin
          if (n.out_month <= 4'd1) begin
            n.out_month = TOP_MONTH;
            n.out_year  = n.out_year - 16'd1;
          end else if (n.out_month > TOP_MONTH) begin
            n.out_month = TOP_MONTH;  // bad month: no year change
          end else n.out_month = n.out_month - 4'd1;
          n.out_day = days_tab[n.out_month];
        end else n.out_day = n.out_day - 5'd1;
      end
      return n;
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function void note_cmd(cmd_t c);
      now_state = step_clock(now_state, c);
      expected_times.push_back(now_state);
    endfunction

    task check_res(res_t r);
      res_t want;
      if (expected_times.size() == 0) begin
        report("result word with none pending");
      end else begin
        want = expected_times.pop_front();
        compare_field("out_second", r.out_second, want.out_second);
        compare_field("out_minute", r.out_minute, want.out_minute);
        compare_field("out_hour",   r.out_hour,   want.out_hour);
        compare_field("out_day",    r.out_day,    want.out_day);
        compare_field("out_month",  r.out_month,  want.out_month);
        compare_field("out_year",   r.out_year,   want.out_year);
      end
    endtask

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  clock_tracker tracker = new();
  bit           tx_busy = 1'b1;
  bit           rx_busy = 1'b1;
  int           idle_cycles = 0;

  up_down_calendar_clock u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) tracker.note_cmd(cmd);
      if (res_valid && res_ready) tracker.check_res(res);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Payload bits other than the ones the kind uses are random.
  function automatic cmd_t step_word(logic [3:0] k);
    logic [63:0] raw;
    cmd_t        c;
    raw    = {$urandom, $urandom};
    c      = raw[$bits(cmd_t)-1:0];
    c.kind = k;
    return c;
  endfunction

  function automatic cmd_t load_word(int s, int mi, int h, int d, int mo, int y);
    cmd_t c;
    c             = step_word(KIND_LOAD);
    c.load_second = 6'(s);
    c.load_minute = 6'(mi);
    c.load_hour   = 5'(h);
    c.load_day    = 5'(d);
    c.load_month  = 4'(mo);
    c.load_year   = 16'(y);
    return c;
  endfunction

  function automatic int edge_pick(int lo, int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // Mostly legal values near the wrap points; now and then raw bits.
  function automatic cmd_t random_load();
    cmd_t c;
    c = step_word(KIND_LOAD);
    if ($urandom_range(0, 7) != 0) begin
      c.load_second = 6'(edge_pick(0, 59));
      c.load_minute = 6'(edge_pick(0, 59));
      c.load_hour   = 5'(edge_pick(0, 23));
      c.load_day    = $urandom_range(0, 1) ? 5'(edge_pick(1, 31)) : 5'($urandom_range(28, 31));
      c.load_month  = 4'(edge_pick(1, 12));
      c.load_year   = 16'(edge_pick(0, 65535));
    end
    return c;
  endfunction

  task automatic send_cmd(cmd_t c);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_busy = !tx_busy;
    gap = tx_busy ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int got;
    int stall;
    got = 0;
    forever begin
      if ($urandom_range(0, 49) == 0) rx_busy = !rx_busy;
      if (got == HOLD_AT) stall = HOLD_CYCLES;
      else stall = rx_busy ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clk);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready <= 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      got++;
    end
  end

  initial begin
    cmd_t       c;
    int         r;
    logic [3:0] last_kind;
    last_kind = KIND_SEC_UP;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // from reset: a second back borrows all the way into the previous year
    send_cmd(step_word(KIND_SEC_DN));
    send_cmd(step_word(KIND_SEC_UP));
    send_cmd(step_word(KIND_MIN_DN));
    send_cmd(step_word(KIND_MIN_UP));
    send_cmd(step_word(KIND_HOUR_DN));
    send_cmd(step_word(KIND_HOUR_UP));
    send_cmd(step_word(KIND_DAY_DN));
    send_cmd(step_word(KIND_DAY_UP));
    // year wrap both ways
    send_cmd(load_word(59, 59, 23, 31, 12, 65535));
    send_cmd(step_word(KIND_SEC_UP));
    send_cmd(step_word(KIND_SEC_DN));
    // all fields at their top bit pattern: up wraps, down only decrements
    send_cmd(load_word(63, 63, 31, 31, 15, 65535));
    send_cmd(step_word(KIND_SEC_UP));
    send_cmd(load_word(63, 63, 31, 31, 15, 65535));
    send_cmd(step_word(KIND_SEC_DN));
    // day and month zero
    send_cmd(load_word(0, 0, 0, 0, 0, 0));
    send_cmd(step_word(KIND_DAY_UP));
    send_cmd(load_word(0, 0, 0, 0, 0, 0));
    send_cmd(step_word(KIND_DAY_DN));
    // month above twelve borrows to December without touching the year
    send_cmd(load_word(30, 30, 12, 1, 14, 1234));
    send_cmd(step_word(KIND_DAY_DN));
    // February is always 29 days
    send_cmd(load_word(0, 0, 0, 29, 2, 2001));
    send_cmd(step_word(KIND_DAY_UP));
    send_cmd(step_word(KIND_DAY_DN));
    // spare kinds hold the state
    send_cmd(step_word(KIND_SPARE_LO));
    send_cmd(step_word(KIND_SPARE_HI));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        c = random_load();
      end else if (r < 11) begin
        c = step_word(4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)));
      end else begin
        // runs of the same step drive long carry chains
        if ($urandom_range(0, 1)) last_kind = 4'($urandom_range(KIND_SEC_UP, KIND_DAY_DN));
        c = step_word(last_kind);
      end
      send_cmd(c);
    end

    @(negedge clk);
    cmd_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
